// ===== design/rme_pkg.sv =====
`default_nettype none
package rme_pkg;

  localparam int MAX_POWER_DEF   = 16;
  localparam int COUNT_WIDTH_DEF = 10;
  localparam int FRAC_BITS       = 20;
  localparam int ITER_W          = 10;   // max_iterations field width
  localparam int POWF_W          = 5;    // power_p / power_q field width
  localparam int ACC_W           = 66;   // accumulator of the product unit
  localparam int WIDE_W          = 46;   // dividend / divisor magnitude range

  localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sh7fff_ffff);
  localparam logic signed [ACC_W-1:0] S32_MIN = -ACC_W'(64'sh8000_0000);
  localparam logic signed [ACC_W-1:0] ESC_LIM = ACC_W'(64'sd10000) <<< (2 * FRAC_BITS);
  localparam logic signed [31:0]      Q_ONE   = 32'sd1 <<< FRAC_BITS;

  typedef enum logic [2:0] {
    CFG_A_REAL   = 3'd0,
    CFG_A_IMAG   = 3'd1,
    CFG_POWER_P  = 3'd2,
    CFG_POWER_Q  = 3'd3,
    CFG_MAX_ITER = 3'd4
  } cfg_idx_e;

  // control of the shared complex product unit
  typedef struct packed {
    logic start;
    logic conj;     // multiply by the conjugate of b
    logic noshift;  // keep full products (exact magnitude test)
  } cmac_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX)      r = 32'sh7fff_ffff;
    else if (v < S32_MIN) r = 32'sh8000_0000;
    else                  r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/rational_map_escape_time.sv =====
`default_nettype none
// Escape-time iteration of x -> x^p (x^q - a) / (1 - a x^q) + c in signed Q12.20, starting
// from x = 0. Pulse start_i while busy_o is low to transfer one point c (pixel_re_i,
// pixel_im_i); busy_o stays high until the result is shown. done_o is high for exactly one
// cycle with escape_count_o and stayed_bounded_o valid; the receiver cannot stall, so it
// must capture them in that cycle. A zero denominator counts as escape after that
// iteration. Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once
// and must only be made while busy_o is low; unknown indexes are ignored.
// Every arithmetic step runs through one shared 32x32 multiplier and one bit-serial
// divider.
module rational_map_escape_time import rme_pkg::*; #(
  parameter int MAX_POWER   = MAX_POWER_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic signed [31:0]     pixel_re_i,
  input  logic signed [31:0]     pixel_im_i,
  output logic                   done_o,
  output logic [COUNT_WIDTH-1:0] escape_count_o,
  output logic                   stayed_bounded_o,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_wdata_i
);

  localparam int PW = $clog2(MAX_POWER + 1);

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CHK  = 13'b0000000000010,
    S_ESC  = 13'b0000000000100,
    S_PWP  = 13'b0000000001000,
    S_PWQ  = 13'b0000000010000,
    S_NUM  = 13'b0000000100000,
    S_DEN  = 13'b0000001000000,
    S_MAG  = 13'b0000010000000,
    S_WGT  = 13'b0000100000000,
    S_DVR  = 13'b0001000000000,
    S_DVI  = 13'b0010000000000,
    S_UPD  = 13'b0100000000000,
    S_FIN  = 13'b1000000000000
  } state_e;

  state_e state_q;

  // configuration
  logic signed [31:0] a_re_q, a_im_q;
  logic [POWF_W-1:0]  pow_p_q, pow_q_q;
  logic [ITER_W-1:0]  max_iter_q;

  // iteration state
  logic signed [31:0] cr_q, ci_q, xr_q, xi_q, tr_q, ti_q, ur_q, ui_q;
  logic signed [31:0] nr_q, ni_q, dr_q, di_q, vr_q;
  logic [WIDE_W-1:0]  mag_q;
  logic signed [WIDE_W-1:0] wr_q, wi_q;
  logic [ITER_W-1:0]  cnt_q;
  logic [PW-1:0]      pl_q, ql_q, pj_q, qj_q;
  logic               wait_q;

  // shared units
  cmac_ctl_t               mac_ctl;
  logic signed [31:0]      op_ar, op_ai, op_br, op_bi;
  logic                    mac_done, div_done, div_start;
  logic signed [ACC_W-1:0] s0, s1;
  logic signed [WIDE_W-1:0] div_w;
  logic signed [31:0]      div_q;
  logic                    pow_p_end, pow_q_end, mac_state;

  function automatic logic [PW-1:0] clamp_pow(input logic [POWF_W-1:0] e);
    logic [PW-1:0] r;
    if (e == '0)                 r = PW'(1);
    else if (int'(e) > MAX_POWER) r = PW'(MAX_POWER);
    else                         r = PW'(e);
    return r;
  endfunction

  always_comb begin
    pow_p_end = pj_q >= pl_q;
    pow_q_end = qj_q >= ql_q;
    mac_state = (state_q == S_ESC) || (state_q == S_PWP && !pow_p_end) ||
                (state_q == S_PWQ && !pow_q_end) || (state_q == S_NUM) ||
                (state_q == S_DEN) || (state_q == S_MAG) || (state_q == S_WGT);
    mac_ctl.start   = mac_state && !wait_q;
    mac_ctl.conj    = (state_q == S_ESC) || (state_q == S_MAG) || (state_q == S_WGT);
    mac_ctl.noshift = (state_q == S_ESC);
    op_ar = xr_q; op_ai = xi_q; op_br = xr_q; op_bi = xi_q;
    unique case (state_q)
      S_PWP: begin op_ar = tr_q; op_ai = ti_q; end
      S_PWQ: begin op_ar = ur_q; op_ai = ui_q; end
      S_NUM: begin
        op_ar = tr_q; op_ai = ti_q;
        op_br = sat32(ACC_W'(ur_q) - ACC_W'(a_re_q));
        op_bi = sat32(ACC_W'(ui_q) - ACC_W'(a_im_q));
      end
      S_DEN: begin op_ar = a_re_q; op_ai = a_im_q; op_br = ur_q; op_bi = ui_q; end
      S_MAG: begin op_ar = dr_q; op_ai = di_q; op_br = dr_q; op_bi = di_q; end
      S_WGT: begin op_ar = nr_q; op_ai = ni_q; op_br = dr_q; op_bi = di_q; end
      default: ;
    endcase
    div_start = ((state_q == S_DVR) || (state_q == S_DVI)) && !wait_q;
    div_w     = (state_q == S_DVI) ? wi_q : wr_q;
  end

  rme_cmac u_cmac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .ar_i   (op_ar),
    .ai_i   (op_ai),
    .br_i   (op_br),
    .bi_i   (op_bi),
    .done_o (mac_done),
    .s0_o   (s0),
    .s1_o   (s1)
  );

  rme_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .w_i     (div_w),
    .m_i     (mag_q),
    .done_o  (div_done),
    .q_o     (div_q)
  );

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_re_q     <= 32'sd268435456;
      a_im_q     <= '0;
      pow_p_q    <= POWF_W'(3);
      pow_q_q    <= POWF_W'(8);
      max_iter_q <= ITER_W'(200);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_A_REAL:   a_re_q     <= cfg_wdata_i;
        CFG_A_IMAG:   a_im_q     <= cfg_wdata_i;
        CFG_POWER_P:  pow_p_q    <= cfg_wdata_i[POWF_W-1:0];
        CFG_POWER_Q:  pow_q_q    <= cfg_wdata_i[POWF_W-1:0];
        CFG_MAX_ITER: max_iter_q <= cfg_wdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
      cnt_q   <= '0;
      pj_q    <= '0;
      qj_q    <= '0;
      pl_q    <= '0;
      ql_q    <= '0;
    end else begin
      if (mac_ctl.start || div_start) wait_q <= 1'b1;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cr_q    <= pixel_re_i;
            ci_q    <= pixel_im_i;
            xr_q    <= '0;
            xi_q    <= '0;
            cnt_q   <= '0;
            pl_q    <= clamp_pow(pow_p_q);
            ql_q    <= clamp_pow(pow_q_q);
            state_q <= S_CHK;
          end
        end
        S_CHK: state_q <= (cnt_q >= max_iter_q) ? S_FIN : S_ESC;
        S_ESC: begin
          if (mac_done) begin
            wait_q <= 1'b0;
            if (s0 < ESC_LIM) begin
              tr_q    <= xr_q;
              ti_q    <= xi_q;
              pj_q    <= PW'(1);
              state_q <= S_PWP;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_PWP: begin
          if (!wait_q && pow_p_end) begin
            ur_q    <= xr_q;
            ui_q    <= xi_q;
            qj_q    <= PW'(1);
            state_q <= S_PWQ;
          end else if (mac_done) begin
            wait_q <= 1'b0;
            tr_q   <= sat32(s0);
            ti_q   <= sat32(s1);
            pj_q   <= pj_q + PW'(1);
          end
        end
        S_PWQ: begin
          if (!wait_q && pow_q_end) begin
            state_q <= S_NUM;
          end else if (mac_done) begin
            wait_q <= 1'b0;
            ur_q   <= sat32(s0);
            ui_q   <= sat32(s1);
            qj_q   <= qj_q + PW'(1);
          end
        end
        S_NUM: begin
          if (mac_done) begin
            wait_q  <= 1'b0;
            nr_q    <= sat32(s0);
            ni_q    <= sat32(s1);
            state_q <= S_DEN;
          end
        end
        S_DEN: begin
          if (mac_done) begin
            wait_q  <= 1'b0;
            dr_q    <= sat32(ACC_W'(Q_ONE) - ACC_W'(sat32(s0)));
            di_q    <= sat32(-ACC_W'(sat32(s1)));
            state_q <= S_MAG;
          end
        end
        S_MAG: begin
          if (mac_done) begin
            wait_q <= 1'b0;
            mag_q  <= s0[WIDE_W-1:0];
            if (s0 == '0) begin
              // zero denominator: escape, but this iteration still counts
              cnt_q   <= cnt_q + ITER_W'(1);
              state_q <= S_FIN;
            end else begin
              state_q <= S_WGT;
            end
          end
        end
        S_WGT: begin
          if (mac_done) begin
            wait_q  <= 1'b0;
            wr_q    <= s0[WIDE_W-1:0];
            wi_q    <= s1[WIDE_W-1:0];
            state_q <= S_DVR;
          end
        end
        S_DVR: begin
          if (div_done) begin
            wait_q  <= 1'b0;
            vr_q    <= div_q;
            state_q <= S_DVI;
          end
        end
        S_DVI: begin
          if (div_done) begin
            wait_q  <= 1'b0;
            xi_q    <= sat32(ACC_W'(div_q) + ACC_W'(ci_q));
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          xr_q    <= sat32(ACC_W'(vr_q) + ACC_W'(cr_q));
          cnt_q   <= cnt_q + ITER_W'(1);
          state_q <= S_CHK;
        end
        S_FIN: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = (state_q == S_FIN);
  assign escape_count_o   = COUNT_WIDTH'(cnt_q);
  assign stayed_bounded_o = (cnt_q >= max_iter_q);

endmodule
`default_nettype wire

// ===== design/rme_cmac.sv =====
`default_nettype none
// Shared complex multiply-accumulate: one 32x32 product per cycle.
// s0 = f(ar*br) -/+ f(ai*bi), s1 = f(ai*br) +/- f(ar*bi), f = floor(>>20) or identity.
module rme_cmac import rme_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmac_ctl_t               ctl_i,
  input  logic signed [31:0]      ar_i,
  input  logic signed [31:0]      ai_i,
  input  logic signed [31:0]      br_i,
  input  logic signed [31:0]      bi_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] s0_o,
  output logic signed [ACC_W-1:0] s1_o
);

  logic                    active_q, done_q, conj_q, nosh_q;
  logic [2:0]              cnt_q;
  logic signed [31:0]      ar_q, ai_q, br_q, bi_q;
  logic signed [63:0]      prod_q;
  logic signed [ACC_W-1:0] s0_q, s1_q, f;
  logic signed [31:0]      mul_a, mul_b;

  always_comb begin
    mul_a = (cnt_q == 3'd0 || cnt_q == 3'd2) ? ar_q : ai_q;
    mul_b = (cnt_q == 3'd0 || cnt_q == 3'd3) ? br_q : bi_q;
    f     = nosh_q ? ACC_W'(prod_q) : ACC_W'(prod_q >>> FRAC_BITS);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= !ctl_i.start && active_q && (cnt_q == 3'd4);
      if (ctl_i.start) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          active_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      ar_q   <= ar_i;
      ai_q   <= ai_i;
      br_q   <= br_i;
      bi_q   <= bi_i;
      conj_q <= ctl_i.conj;
      nosh_q <= ctl_i.noshift;
    end
    prod_q <= mul_a * mul_b;
    if (active_q) begin
      case (cnt_q)
        3'd1:    s0_q <= f;
        3'd2:    s0_q <= conj_q ? s0_q + f : s0_q - f;
        3'd3:    s1_q <= conj_q ? -f : f;
        3'd4:    s1_q <= s1_q + f;
        default: ;
      endcase
    end
  end

  assign done_o = done_q;
  assign s0_o   = s0_q;
  assign s1_o   = s1_q;

endmodule
`default_nettype wire

// ===== design/rme_div.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle: sat32(trunc(w * 2^20 / m)), m > 0.
module rme_div import rme_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [WIDE_W-1:0] w_i,
  input  logic        [WIDE_W-1:0] m_i,
  output logic                     done_o,
  output logic signed [31:0]       q_o
);

  localparam int NUM_W = WIDE_W + FRAC_BITS;
  localparam int REM_W = WIDE_W + 1;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam logic [NUM_W-1:0] POS_MAX = NUM_W'(64'h7fff_ffff);
  localparam logic [NUM_W-1:0] NEG_MAX = NUM_W'(64'h8000_0000);

  logic             run_q, fin_q, done_q, neg_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q, quo_q;
  logic [REM_W-1:0] rem_q, trial;
  logic [WIDE_W-1:0] m_q, w_abs;
  logic             ge;
  logic signed [31:0] res_q;

  always_comb begin
    w_abs = w_i[WIDE_W-1] ? WIDE_W'(-w_i) : WIDE_W'(w_i);
    trial = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
    ge    = trial >= {1'b0, m_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= !start_i && run_q && (cnt_q == CNT_W'(NUM_W - 1));
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= w_i[WIDE_W-1];
      m_q   <= m_i;
      num_q <= {w_abs, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NUM_W-2:0], 1'b0};
      rem_q <= ge ? trial - {1'b0, m_q} : trial;
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
    if (fin_q) begin
      if (!neg_q) res_q <= (quo_q > POS_MAX) ? 32'sh7fff_ffff : $signed(quo_q[31:0]);
      else        res_q <= (quo_q > NEG_MAX) ? 32'sh8000_0000 : $signed(-quo_q[31:0]);
    end
  end

  assign done_o = done_q;
  assign q_o    = res_q;

endmodule
`default_nettype wire

// ===== design/rme_checker.sv =====
`default_nettype none
module rme_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic done_o
);

  // a result is only shown while the item is still owned
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("done without busy");

  // every transfer starts a busy period
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  // busy ends right after the result strobe
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy_o && !done_o)) else $error("busy held after result");

  // busy never drops without a result
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> $past(done_o)) else $error("item dropped without result");

endmodule

bind rational_map_escape_time rme_checker u_rme_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);
`default_nettype wire

// ===== sim/rational_map_escape_time_tb.sv =====
`timescale 1ns / 1ps
module rational_map_escape_time_tb;
  import rme_pkg::*;

  // Register index that the block does not decode; writes to it must be dropped.
  localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;
  localparam longint     S32_HI         = 64'sd2147483647;
  localparam longint     S32_LO         = -64'sd2147483648;
  localparam logic signed [31:0] FULL_POS = 32'sh7fff_ffff;
  localparam logic signed [31:0] FULL_NEG = 32'sh8000_0000;
  localparam logic signed [31:0] ONE_Q    = 32'sh0010_0000;

  typedef struct packed {
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic [4:0]         pw_p;
    logic [4:0]         pw_q;
    logic [9:0]         limit;
  } map_cfg_t;

  typedef struct packed {
    logic [9:0] count;
    logic       bounded;
  } escape_t;

  // One directed transfer: optional register update first, optional fixed answer.
  typedef struct packed {
    logic               load_cfg;
    map_cfg_t           cfg;
    logic signed [31:0] c_re;
    logic signed [31:0] c_im;
    logic               fixed;
    escape_t            answer;
  } dir_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [31:0] pixel_re_i;
  logic signed [31:0] pixel_im_i;
  logic               done_o;
  logic [9:0]         escape_count_o;
  logic               stayed_bounded_o;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [31:0]        cfg_wdata_i;

  rational_map_escape_time i_dut (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .pixel_re_i,
    .pixel_im_i,
    .done_o,
    .escape_count_o,
    .stayed_bounded_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i
  );

  map_cfg_t map_cfg;        // tb copy of the register file
  escape_t  pending_q[$];   // escape results still owed by the block
  int       fails     = 0;
  int       n_results = 0;
  int       n_bounded = 0;
  int       n_points  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop far above the slowest legal run.
  initial begin
    #100_000_000;
    $display("rational_map_escape_time_tb failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point predictor
  // ---------------------------------------------------------------------------
  function automatic longint sat_q(longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  // Exact product, floor-shifted back to Q12.20.
  function automatic longint fix_mul(longint x, longint y);
    return (x * y) >>> FRAC_BITS;
  endfunction

  function automatic void cplx_mul(input longint ar, ai, br, bi, output longint rr, ri);
    rr = sat_q(fix_mul(ar, br) - fix_mul(ai, bi));
    ri = sat_q(fix_mul(ar, bi) + fix_mul(ai, br));
  endfunction

  function automatic void cplx_pow(input longint xr, xi, input int e, output longint rr, ri);
    longint pr, pi;
    pr = xr;
    pi = xi;
    for (int j = 1; j < e; j++) cplx_mul(pr, pi, xr, xi, pr, pi);
    rr = pr;
    ri = pi;
  endfunction

  // w * 2^20 / m, truncated toward zero, saturated; m > 0.
  function automatic longint fix_div(longint w, longint m);
    longint unsigned n, um, quo, rem, res;
    logic neg;
    neg = w < 0;
    n   = neg ? longint'(-w) : w;
    um  = m;
    quo = n / um;
    rem = n % um;
    if (quo >= (64'd1 << 32)) return neg ? S32_LO : S32_HI;
    res = (quo << FRAC_BITS) + (rem << FRAC_BITS) / um;
    if (res > (64'd1 << 32)) res = 64'd1 << 32;
    return sat_q(neg ? -longint'(res) : longint'(res));
  endfunction

  function automatic int clamp_exp(logic [4:0] e);
    if (e < 1) return 1;
    if (e > MAX_POWER_DEF) return MAX_POWER_DEF;
    return int'(e);
  endfunction

  function automatic escape_t predict_escape(map_cfg_t cfg, longint cr, longint ci);
    longint xr, xi, tr, ti, ur, ui, nr, ni, mr, mi, dr, di, mag;
    longint unsigned norm;
    int      pe, qe, iter;
    logic    escaped;
    escape_t r;
    xr = 0;
    xi = 0;
    pe = clamp_exp(cfg.pw_p);
    qe = clamp_exp(cfg.pw_q);
    iter = 0;
    escaped = 1'b0;
    forever begin
      norm = longint'(xr * xr) + longint'(xi * xi);
      if (iter >= cfg.limit || escaped || norm >= (64'd10000 << (2 * FRAC_BITS))) break;
      cplx_pow(xr, xi, pe, tr, ti);
      cplx_pow(xr, xi, qe, ur, ui);
      cplx_mul(tr, ti, sat_q(ur - cfg.a_re), sat_q(ui - cfg.a_im), nr, ni);
      cplx_mul(cfg.a_re, cfg.a_im, ur, ui, mr, mi);
      dr  = sat_q(longint'(ONE_Q) - mr);
      di  = sat_q(-mi);
      mag = fix_mul(dr, dr) + fix_mul(di, di);
      if (mag <= 0) begin
        // singular denominator: this iteration still counts, then stop
        escaped = 1'b1;
      end else begin
        xr = sat_q(fix_div(fix_mul(nr, dr) + fix_mul(ni, di), mag) + cr);
        xi = sat_q(fix_div(fix_mul(ni, dr) - fix_mul(nr, di), mag) + ci);
      end
      iter++;
    end
    r.count   = iter[9:0];
    r.bounded = iter >= cfg.limit;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: sampled at the falling edge, the strobe lasts one cycle
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    escape_t want;
    if (rst_ni && done_o) begin
      n_results++;
      n_bounded += stayed_bounded_o;
      if (pending_q.size() == 0) begin
        $error("result transfer with nothing outstanding: count %0d", escape_count_o);
        fails++;
      end else begin
        want = pending_q.pop_front();
        if (escape_count_o !== want.count) begin
          $error("escape_count: expected %0d, got %0d", want.count, escape_count_o);
          fails++;
        end
        if (stayed_bounded_o !== want.bounded) begin
          $error("stayed_bounded: expected %0b, got %0b", want.bounded, stayed_bounded_o);
          fails++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  logic burst;  // stretch of back-to-back transfers

  // start_i may stay high from the previous transfer; it is only lowered when a gap follows.
  task automatic send_point(logic signed [31:0] re, logic signed [31:0] im,
                            logic fixed, escape_t answer);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    pixel_re_i <= re;
    pixel_im_i <= im;
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    pending_q.push_back(fixed ? answer : predict_escape(map_cfg, re, im));
    n_points++;
  endtask

  // Let every outstanding result arrive; the block is idle afterwards.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_map(map_cfg_t cfg);
    drain();
    write_reg(CFG_A_REAL, cfg.a_re);
    write_reg(CFG_A_IMAG, cfg.a_im);
    write_reg(CFG_POWER_P, 32'(cfg.pw_p));
    write_reg(CFG_POWER_Q, 32'(cfg.pw_q));
    write_reg(CFG_MAX_ITER, 32'(cfg.limit));
    write_reg(CFG_UNUSED_IDX, $urandom());  // must be dropped
    cfg_we_i <= 1'b0;
    map_cfg = cfg;
    @(posedge clk_i);
  endtask

  function automatic map_cfg_t mk_cfg(logic signed [31:0] ar, ai, logic [4:0] p, q,
                                      logic [9:0] lim);
    map_cfg_t c;
    c.a_re  = ar;
    c.a_im  = ai;
    c.pw_p  = p;
    c.pw_q  = q;
    c.limit = lim;
    return c;
  endfunction

  function automatic dir_row_t row(logic ld, map_cfg_t cfg, logic signed [31:0] re, im,
                                   logic fixed, logic [9:0] cnt, logic bnd);
    dir_row_t r;
    r.load_cfg       = ld;
    r.cfg            = cfg;
    r.c_re           = re;
    r.c_im           = im;
    r.fixed          = fixed;
    r.answer.count   = cnt;
    r.answer.bounded = bnd;
    return r;
  endfunction

  // Mostly points within +-4.0, where orbits live longer; the rest anywhere.
  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 9) < 6) return $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
    return $urandom();
  endfunction

  function automatic map_cfg_t rand_cfg();
    map_cfg_t c;
    c.a_re  = $urandom_range(0, 1) ? $urandom() : $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    c.a_im  = $urandom_range(0, 1) ? $urandom() : $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    // wide exponents are rare so that iterations stay cheap
    c.pw_p  = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 5));
    c.pw_q  = $urandom_range(0, 3) == 0 ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 5));
    c.limit = 10'($urandom_range(0, 24));
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    map_cfg_t rst_cfg, zdiv_cfg;
    dir_row_t dir[$];
    escape_t  none;

    none        = '0;
    start_i     = 1'b0;
    pixel_re_i  = '0;
    pixel_im_i  = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_A_REAL;
    cfg_wdata_i = '0;
    burst       = 1'b0;
    rst_ni      = 1'b0;
    rst_cfg     = mk_cfg(32'sh1000_0000, 32'sh0, 5'd3, 5'd8, 10'd200);
    map_cfg     = rst_cfg;
    // a = 1.0, p = q = 1, c = 1.0: the second iteration hits 1 - a*x = 0
    zdiv_cfg    = mk_cfg(ONE_Q, 32'sh0, 5'd1, 5'd1, 10'd200);

    // reset values: any point far outside escapes on its first step
    dir.push_back(row(0, rst_cfg, FULL_POS, FULL_POS, 1, 10'd1, 0));
    dir.push_back(row(0, rst_cfg, FULL_NEG, FULL_NEG, 1, 10'd1, 0));
    dir.push_back(row(0, rst_cfg, FULL_NEG, FULL_POS, 1, 10'd1, 0));
    dir.push_back(row(0, rst_cfg, 32'sh0, 32'sh0, 0, 10'd0, 0));
    dir.push_back(row(0, rst_cfg, ONE_Q, -ONE_Q, 0, 10'd0, 0));
    // singular denominator counts as escape after the iteration
    dir.push_back(row(1, zdiv_cfg, ONE_Q, 32'sh0, 1, 10'd2, 0));
    dir.push_back(row(0, zdiv_cfg, -ONE_Q, 32'sh0, 0, 10'd0, 0));
    // zero iteration limit: nothing runs, reported as bounded
    dir.push_back(row(1, mk_cfg(FULL_NEG, FULL_POS, 5'd16, 5'd16, 10'd0),
                      32'sh0, 32'sh0, 1, 10'd0, 1));
    // limit 1 with exponents out of range (p=0, q=31 clamp to 1 and 16)
    dir.push_back(row(1, mk_cfg(FULL_POS, FULL_NEG, 5'd0, 5'd31, 10'd1),
                      32'sh0, 32'sh0, 1, 10'd1, 1));
    dir.push_back(row(0, map_cfg, 32'sh0004_0000, 32'shfffc_0000, 0, 10'd0, 0));
    // largest limit and exponents with far points, so runs stay short; then a = 0, p = 2, q = 1
    dir.push_back(row(1, mk_cfg(FULL_NEG, FULL_POS, 5'd31, 5'd0, 10'd1023),
                      FULL_POS, FULL_NEG, 1, 10'd1, 0));
    dir.push_back(row(0, map_cfg, 32'sh0, FULL_NEG, 1, 10'd1, 0));
    dir.push_back(row(1, mk_cfg(FULL_POS, FULL_NEG, 5'd16, 5'd16, 10'd1023),
                      32'sh6400_0000, 32'sh0, 0, 10'd0, 0));
    dir.push_back(row(1, mk_cfg(32'sh0, 32'sh0, 5'd2, 5'd1, 10'd20),
                      32'shffe0_0000, 32'sh0, 0, 10'd0, 0));
    dir.push_back(row(0, map_cfg, 32'sh0008_0000, 32'sh0008_0000, 0, 10'd0, 0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (dir[k]) begin
      if (dir[k].load_cfg) load_map(dir[k].cfg);
      send_point(dir[k].c_re, dir[k].c_im, dir[k].fixed, dir[k].answer);
    end

    // random part: new register set every dozen transfers
    for (int n = 0; n < 100; n++) begin
      if (n % 12 == 0) load_map(rand_cfg());
      else if (n == 30) drain();  // sender holds off until nothing is owed
      if (n % 7 == 0) burst = $urandom_range(0, 1);
      send_point(rand_coord(), rand_coord(), 0, none);
    end

    drain();
    repeat (400) @(posedge clk_i);
    $display("points sent %0d, results %0d (%0d bounded, %0d escaped)",
             n_points, n_results, n_bounded, n_results - n_bounded);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("rational_map_escape_time_tb passed");
    end else begin
      if (pending_q.size() != 0) $error("%0d results never arrived", pending_q.size());
      $display("rational_map_escape_time_tb failed");
    end
    $finish;
  end

endmodule
